/* design/fit_policy_partition_allocator_macros.svh */
// Assertion macros used by the allocator checker.
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

/* design/fpa_pkg.sv */
// Shared codes and widths of the partition allocator.
package fpa_pkg;

   // Fixed field widths
   localparam int OPCODE_W   = 2;
   localparam int IN_INDEX_W = 4;
   localparam int IN_SIZE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int POLICY_W   = 2;
   localparam int COUNT_W    = 5;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [POLICY_W-1:0]  policy_type;

   // Item opcodes
   localparam opcode_type OP_LOAD    = 2'd0;
   localparam opcode_type OP_REQUEST = 2'd1;
   localparam opcode_type OP_CLEAR   = 2'd2;

   // Register indexes
   localparam csr_index_type CSR_FIT_POLICY  = 2'd0;
   localparam csr_index_type CSR_BLOCK_COUNT = 2'd1;

   // Fit policies; the unused code behaves as first fit
   localparam policy_type POL_FIRST = 2'd0;
   localparam policy_type POL_BEST  = 2'd1;
   localparam policy_type POL_WORST = 2'd2;

endpackage

/* design/fit_policy_partition_allocator.sv */
// Fixed-partition allocator with first, best and worst fit over a size memory.
// Load and clear items finish in the cycle they are accepted and give no result.
// A request item scans the partition size memory one entry per cycle, from index
// zero up to but not including min(block_count, MAX_BLOCKS), with a registered
// memory read feeding the compare stage; the input is busy from the accept until
// the result is handed to the output register, so no new item is taken while a
// request scans. The single memory read port sets the scan rate. One result per
// request is held in an output register, so the next item can be taken while
// it waits; a request that finishes while that result is still stalled holds
// the input busy until the output register frees. Used marks live in flip-flops
// and are cleared by reset and by a clear item; partition sizes are undefined
// until loaded.
module fit_policy_partition_allocator #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fpa_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [fpa_pkg::IN_INDEX_W-1:0]      req_block_index,
   input  logic [fpa_pkg::IN_SIZE_W-1:0]       req_size_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_granted,
   output logic [fpa_pkg::IN_INDEX_W-1:0]      rsp_block_number,
   output logic [fpa_pkg::IN_SIZE_W-1:0]       rsp_block_size,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Configuration registers
   logic [fpa_pkg::POLICY_W-1:0] policy_ff;
   logic [fpa_pkg::COUNT_W-1:0]  count_ff;

   // Control state
   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic                  pvld_ff, pvld_in;
   logic [IDX_W-1:0]      pidx_ff, pidx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_BITS-1:0]  pick_size_ff, pick_size_in;
   logic [SIZE_BITS-1:0]  want_ff, want_in;
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff;
   logic [fpa_pkg::IN_INDEX_W-1:0] rsp_number_ff;
   logic [fpa_pkg::IN_SIZE_W-1:0]  rsp_size_ff;

   // Size memory
   logic [SIZE_BITS-1:0]  size_mem [MAX_BLOCKS];
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_en;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;

   // Widened views for explicit resizing
   logic [SIZE_BITS+fpa_pkg::IN_SIZE_W-1:0]  req_size_ext;
   logic [IDX_W+fpa_pkg::IN_INDEX_W-1:0]     load_idx_ext;
   logic [CNT_W+fpa_pkg::COUNT_W-1:0]        count_ext;
   logic [IDX_W+fpa_pkg::IN_INDEX_W-1:0]     pick_ext;
   logic [SIZE_BITS+fpa_pkg::IN_SIZE_W-1:0]  pick_size_ext;

   logic in_accept;
   logic out_free;
   logic fits;
   logic take;

   assign in_accept = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign req_size_ext  = {{SIZE_BITS{1'b0}}, req_size_value};
   assign load_idx_ext  = {{IDX_W{1'b0}}, req_block_index};
   assign count_ext     = {{CNT_W{1'b0}}, count_ff};
   assign pick_ext      = {{fpa_pkg::IN_INDEX_W{1'b0}}, pick_ff};
   assign pick_size_ext = {{fpa_pkg::IN_SIZE_W{1'b0}}, pick_size_ff};

   // Write a loaded size when the index is in range
   assign wr_en   = in_accept && (req_opcode == fpa_pkg::OP_LOAD)
                    && (load_idx_ext < (IDX_W + fpa_pkg::IN_INDEX_W)'(MAX_BLOCKS));
   assign wr_addr = load_idx_ext[IDX_W-1:0];
   assign rd_en   = (state_ff == ST_SCAN) && (scan_ff < limit_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         size_mem[wr_addr] <= req_size_ext[SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= size_mem[scan_ff[IDX_W-1:0]];
      end
   end

   // Compare stage: a free entry that fits replaces the pick per policy
   assign fits = pvld_ff && !used_ff[pidx_ff] && (rd_data_ff >= want_ff);
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (policy_ff == fpa_pkg::POL_BEST) begin
            take = (rd_data_ff <= pick_size_ff);
         end else if (policy_ff == fpa_pkg::POL_WORST) begin
            take = (rd_data_ff >= pick_size_ff);
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      limit_in     = limit_ff;
      pvld_in      = 1'b0;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      want_in      = want_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (in_accept && (req_opcode == fpa_pkg::OP_CLEAR)) begin
               used_in = '0;
            end
            if (in_accept && (req_opcode == fpa_pkg::OP_REQUEST)) begin
               state_in = ST_SCAN;
               scan_in  = '0;
               found_in = 1'b0;
               pick_in  = '0;
               want_in  = req_size_ext[SIZE_BITS-1:0];
               if (count_ext > (CNT_W + fpa_pkg::COUNT_W)'(MAX_BLOCKS)) begin
                  limit_in = CNT_W'(MAX_BLOCKS);
               end else begin
                  limit_in = count_ext[CNT_W-1:0];
               end
            end
         end
         ST_SCAN: begin
            // issue the next read, evaluate the one returned
            if (rd_en) begin
               pvld_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
            if (take) begin
               found_in     = 1'b1;
               pick_in      = pidx_ff;
               pick_size_in = rd_data_ff;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found_ff) begin
                  used_in[pick_ff] = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         limit_ff     <= '0;
         pvld_ff      <= 1'b0;
         found_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         limit_ff     <= limit_in;
         pvld_ff      <= pvld_in;
         found_ff     <= found_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      want_ff      <= want_in;
   end

   // Load the result register when the scan hands over
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_granted_ff <= found_ff;
         if (found_ff) begin
            rsp_number_ff <= pick_ext[fpa_pkg::IN_INDEX_W-1:0];
            rsp_size_ff   <= pick_size_ext[fpa_pkg::IN_SIZE_W-1:0];
         end else begin
            rsp_number_ff <= '0;
            rsp_size_ff   <= '0;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fpa_pkg::POL_FIRST;
         count_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fpa_pkg::CSR_FIT_POLICY:  policy_ff <= csr_wdata[fpa_pkg::POLICY_W-1:0];
            fpa_pkg::CSR_BLOCK_COUNT: count_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_block_number = rsp_number_ff;
   assign rsp_block_size   = rsp_size_ff;

endmodule

/* design/fpa_checker.sv */
// Port-level checker for the partition allocator, bound to the top level.
`include "fit_policy_partition_allocator_macros.svh"

module fpa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [fpa_pkg::OPCODE_W-1:0]        req_opcode,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_granted,
   input logic [fpa_pkg::IN_INDEX_W-1:0]      rsp_block_number,
   input logic [fpa_pkg::IN_SIZE_W-1:0]       rsp_block_size
);

   // A stalled item stays offered
   `FPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled item keeps its fields
   `FPA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_granted) && $stable(rsp_block_number) && $stable(rsp_block_size))

   // A refusal carries zero index and size
   `FPA_ASSERT_NOW(a_refuse_zero, clock, reset, rsp_valid && !rsp_granted, (rsp_block_number == '0) && (rsp_block_size == '0))

   // An accepted request occupies the scan, so input stalls next cycle
   `FPA_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall && (req_opcode == fpa_pkg::OP_REQUEST), req_stall)

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted      (rsp_granted),
   .rsp_block_number (rsp_block_number),
   .rsp_block_size   (rsp_block_size)
);

/* dv/tb.sv */
// Self-checking testbench for the fixed-partition fit-policy allocator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Codes the package leaves unnamed
   localparam fpa_pkg::opcode_type OP_UNUSED  = 2'd3;
   localparam fpa_pkg::policy_type POL_UNUSED = 2'd3;

   localparam int NUM_PARTS      = 16;
   localparam int PHASE_ITEMS    = 95;
   localparam int NUM_PHASES     = 11;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      fpa_pkg::opcode_type                opcode;
      logic [fpa_pkg::IN_INDEX_W-1:0]     index;
      logic [fpa_pkg::IN_SIZE_W-1:0]      size;
   } alloc_item_type;

   typedef struct packed {
      logic                               granted;
      logic [fpa_pkg::IN_INDEX_W-1:0]     number;
      logic [fpa_pkg::IN_SIZE_W-1:0]      size;
   } grant_type;

   // Register settings of the random phases; the last one runs without idling
   fpa_pkg::policy_type phase_policy[NUM_PHASES] = '{fpa_pkg::POL_BEST,
      fpa_pkg::POL_WORST, POL_UNUSED, fpa_pkg::POL_FIRST, fpa_pkg::POL_BEST,
      fpa_pkg::POL_WORST, fpa_pkg::POL_BEST, fpa_pkg::POL_FIRST, fpa_pkg::POL_WORST,
      fpa_pkg::POL_BEST, fpa_pkg::POL_FIRST};
   int phase_count[NUM_PHASES] = '{16, 16, 16, 5, 1, 31, 17, 0, 8, 16, 16};

   // Sizes loaded by the directed part: extremes and repeated values for ties
   logic [fpa_pkg::IN_SIZE_W-1:0] seed_sizes[NUM_PARTS] = '{16'd100, 16'd65535,
      16'd0, 16'd100, 16'd4000, 16'd65535, 16'd7, 16'd100, 16'd32768, 16'd1,
      16'd4000, 16'd255, 16'd0, 16'd65534, 16'd7, 16'd4096};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   fpa_pkg::opcode_type            req_opcode = fpa_pkg::OP_LOAD;
   logic [fpa_pkg::IN_INDEX_W-1:0] req_block_index = '0;
   logic [fpa_pkg::IN_SIZE_W-1:0]  req_size_value = '0;

   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_granted;
   logic [fpa_pkg::IN_INDEX_W-1:0] rsp_block_number;
   logic [fpa_pkg::IN_SIZE_W-1:0]  rsp_block_size;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   fpa_pkg::csr_index_type         csr_index = fpa_pkg::CSR_FIT_POLICY;
   logic [fpa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Stimulus and expectations
   alloc_item_type pending_items[$];
   grant_type      expected_grants[$];

   // Shadow of the allocator state
   logic [fpa_pkg::IN_SIZE_W-1:0] part_size[NUM_PARTS];
   bit                            part_used[NUM_PARTS];
   fpa_pkg::policy_type           fit_pol = fpa_pkg::POL_FIRST;
   logic [fpa_pkg::COUNT_W-1:0]   blk_count = '0;

   // Sizes as queued, used to aim request sizes at real partitions
   logic [fpa_pkg::IN_SIZE_W-1:0] queued_size[NUM_PARTS];

   bit idle_on = 1'b1;
   int gap_pct = 10;
   bit req_done = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   int error_count = 0;
   int n_items = 0;
   int n_requests = 0;
   int n_grants = 0;
   int n_results = 0;
   int n_settings = 1;

   fit_policy_partition_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_block_index  (req_block_index),
      .req_size_value   (req_size_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_block_number (rsp_block_number),
      .rsp_block_size   (rsp_block_size),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Apply one item to the shadow state; a request yields one expected grant
   task automatic predict_allocation(input alloc_item_type it);
      int        limit;
      int        pick;
      bit        found;
      grant_type g;
      limit = (blk_count > NUM_PARTS) ? NUM_PARTS : int'(blk_count);
      pick = 0;
      found = 1'b0;
      case (it.opcode)
         fpa_pkg::OP_LOAD: begin
            part_size[it.index] = it.size;
         end
         fpa_pkg::OP_CLEAR: begin
            foreach (part_used[j]) part_used[j] = 1'b0;
         end
         fpa_pkg::OP_REQUEST: begin
            for (int j = 0; j < limit; j++) begin
               if (!part_used[j] && part_size[j] >= it.size) begin
                  case (fit_pol)
                     fpa_pkg::POL_BEST: begin
                        if (!found || part_size[j] <= part_size[pick]) begin
                           pick = j;
                           found = 1'b1;
                        end
                     end
                     fpa_pkg::POL_WORST: begin
                        if (!found || part_size[j] >= part_size[pick]) begin
                           pick = j;
                           found = 1'b1;
                        end
                     end
                     default: begin
                        // first fit: keep the lowest index
                        if (!found) begin
                           pick = j;
                           found = 1'b1;
                        end
                     end
                  endcase
               end
            end
            g = '0;
            if (found) begin
               part_used[pick] = 1'b1;
               g.granted = 1'b1;
               g.number = fpa_pkg::IN_INDEX_W'(pick);
               g.size = part_size[pick];
               n_grants++;
            end
            expected_grants.push_back(g);
            n_requests++;
         end
         default: ;
      endcase
   endtask

   task automatic queue_item(input fpa_pkg::opcode_type op, input int idx, input int sz);
      alloc_item_type it;
      it.opcode = op;
      it.index = fpa_pkg::IN_INDEX_W'(idx);
      it.size = fpa_pkg::IN_SIZE_W'(sz);
      if (op == fpa_pkg::OP_LOAD) queued_size[it.index] = it.size;
      pending_items.push_back(it);
   endtask

   // Mostly requests aimed at loaded sizes, with loads from a small pool for ties
   task automatic queue_random_item();
      int r;
      int k;
      int sz;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, NUM_PARTS - 1);
      if (r < 55) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: sz = int'(fpa_pkg::IN_SIZE_W'(queued_size[k]
                                       + $urandom_range(0, 2) - 1));
            6: sz = 0;
            7: sz = 65535;
            default: sz = $urandom_range(0, 65535);
         endcase
         queue_item(fpa_pkg::OP_REQUEST, $urandom_range(0, 15), sz);
      end else if (r < 85) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: sz = $urandom_range(0, 7) * 500;
            5: sz = $urandom_range(0, 1) ? 65535 : 0;
            default: sz = $urandom_range(0, 65535);
         endcase
         queue_item(fpa_pkg::OP_LOAD, k, sz);
      end else if (r < 93) begin
         queue_item(fpa_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 65535));
      end else begin
         queue_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 65535));
      end
   endtask

   // Wait until every item is taken and every grant has come back
   task automatic drain_items(input int settle);
      while (pending_items.size() != 0 || req_valid || expected_grants.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input fpa_pkg::csr_index_type idx,
                                 input logic [fpa_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == fpa_pkg::CSR_FIT_POLICY)
         fit_pol = fpa_pkg::policy_type'(data[fpa_pkg::POLICY_W-1:0]);
      else if (idx == fpa_pkg::CSR_BLOCK_COUNT)
         blk_count = data;
   endtask

   // Take a new setting; policy data carries random upper bits
   task automatic set_registers(input fpa_pkg::policy_type pol, input int count);
      logic [fpa_pkg::CSR_DATA_W-1:0] pol_data;
      pol_data = {3'($urandom_range(0, 7)), pol};
      if ($urandom_range(0, 1)) begin
         write_register(fpa_pkg::CSR_FIT_POLICY, pol_data);
         write_register(fpa_pkg::CSR_BLOCK_COUNT, fpa_pkg::CSR_DATA_W'(count));
      end else begin
         write_register(fpa_pkg::CSR_BLOCK_COUNT, fpa_pkg::CSR_DATA_W'(count));
         write_register(fpa_pkg::CSR_FIT_POLICY, pol_data);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // Reset once, then directed items, then random phases
   initial begin
      foreach (part_size[j]) part_size[j] = '0;
      foreach (part_used[j]) part_used[j] = 1'b0;
      foreach (queued_size[j]) queued_size[j] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Load every partition before any search; a request at count zero never grants
      for (int j = 0; j < NUM_PARTS; j++)
         queue_item(fpa_pkg::OP_LOAD, j, int'(seed_sizes[j]));
      queue_item(fpa_pkg::OP_REQUEST, 0, 0);
      queue_item(OP_UNUSED, 15, 65535);
      drain_items(SETTLE_CYCLES);

      // First fit over all partitions: zero request, largest requests, clear, small request
      set_registers(fpa_pkg::POL_FIRST, NUM_PARTS);
      queue_item(fpa_pkg::OP_REQUEST, 0, 0);
      queue_item(fpa_pkg::OP_REQUEST, 0, 65535);
      queue_item(fpa_pkg::OP_REQUEST, 0, 65535);
      queue_item(fpa_pkg::OP_REQUEST, 0, 65535);
      queue_item(fpa_pkg::OP_CLEAR, 0, 0);
      queue_item(fpa_pkg::OP_REQUEST, 0, 1);
      drain_items(SETTLE_CYCLES);

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_registers(phase_policy[p], phase_count[p]);
         if (p == NUM_PHASES - 1) idle_on = 1'b0;
         else gap_pct = $urandom_range(0, 2) * 15;
         for (int n = 0; n < PHASE_ITEMS; n++) queue_random_item();
         drain_items(SETTLE_CYCLES);
      end

      drain_items(40);
      $display("Ran %0d items across %0d register settings: %0d requests, %0d granted",
               n_items, n_settings, n_requests, n_grants);
      $display("Checked %0d results, %0d mismatches", n_results, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Note each accepted item and predict its outcome
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_allocation(alloc_item_type'({req_opcode, req_block_index, req_size_value}));
         n_items++;
         req_done = 1'b1;
      end
   end

   // Drive items on the falling edge; hold the payload while stalled
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_done)) begin
         req_done = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(1, 100) <= gap_pct) begin
            send_gap = $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else begin
            req_opcode <= pending_items[0].opcode;
            req_block_index <= pending_items[0].index;
            req_size_value <= pending_items[0].size;
            void'(pending_items.pop_front());
            req_valid <= 1'b1;
         end
      end
   end

   // Stall results in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result with the oldest expected grant; watch for a hang
   always @(posedge clock) begin
      grant_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected result, granted", rsp_granted, 0);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_granted !== want.granted)
                  report_mismatch("granted", rsp_granted, want.granted);
               if (rsp_block_number !== want.number)
                  report_mismatch("block_number", rsp_block_number, want.number);
               if (rsp_block_size !== want.size)
                  report_mismatch("block_size", rsp_block_size, want.size);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without progress, %0d grants outstanding",
                     quiet_cycles, expected_grants.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule

/* filelist.f */
+incdir+design
design/fpa_pkg.sv
design/fit_policy_partition_allocator.sv
design/fpa_checker.sv
dv/tb.sv
